[hw/rtl/tcp_sequence_block_tracker_assert.svh]
// assertion macros shared by the tracker checker
`ifndef TCP_SEQUENCE_BLOCK_TRACKER_ASSERT_SVH
`define TCP_SEQUENCE_BLOCK_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSBT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSBT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tsbt_pkg.sv]
// ----------------------------------------------------------------------------
// tsbt_pkg
// Types, constants and sequence compare helpers for the block tracker.
// ----------------------------------------------------------------------------
package tsbt_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [2:0] {
		OP_ADD_ORD   = 3'd0,
		OP_ADD_UNORD = 3'd1,
		OP_FIND      = 3'd2,
		OP_GAP       = 3'd3,
		OP_PRUNE     = 3'd4,
		OP_LIMIT     = 3'd5,
		OP_CLEAR     = 3'd6
	} op_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] seq_left;
		logic [31:0] seq_right;
		logic [4:0]  keep_count;
	} req_t;

	typedef struct packed {
		logic [31:0] block_left;
		logic [31:0] block_right;
		logic        block_hit;
		logic [31:0] gap_left;
		logic [31:0] gap_right;
		logic        gap_found;
		logic [31:0] skipped_bytes;
		logic [4:0]  block_count;
		logic [31:0] total_bytes;
		logic        is_ordered;
		logic        status;
	} rsp_t;

	typedef struct packed {
		logic [31:0] left_edge;
		logic [31:0] right_edge;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic walk_start;
		logic walk_en;
		logic scan;
		logic ins_en;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_end;
		logic ins_needed;
	} stat_t;

	// a is below b modulo 2^32
	function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

endpackage

[hw/rtl/tsbt_ctrl.sv]
// ----------------------------------------------------------------------------
// tsbt_ctrl
// Sequencer: accepts a request, runs the table walks and the insert write,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module tsbt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [2:0]      req_op,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  tsbt_pkg::stat_t stat,
	output tsbt_pkg::cmd_t  cmd
);
	import tsbt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_COPY = 5'b00100,
		ST_INS  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					priority if (req_op == OP_ADD_ORD)
						state_d = ST_SCAN;
					else if (req_op == OP_ADD_UNORD || req_op == OP_FIND
						|| req_op == OP_GAP || req_op == OP_PRUNE || req_op == OP_LIMIT)
						state_d = ST_COPY;
					else
						state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.walk_en = 1'b1;
				cmd.scan    = 1'b1;
				if (stat.walk_end) begin
					cmd.walk_start = 1'b1;
					state_d        = ST_COPY;
				end
			end
			ST_COPY: begin
				cmd.walk_en = 1'b1;
				if (stat.walk_end)
					state_d = stat.ins_needed ? ST_INS : ST_DONE;
			end
			ST_INS: begin
				cmd.ins_en = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[hw/rtl/tsbt_datapath.sv]
// ----------------------------------------------------------------------------
// tsbt_datapath
// Double-banked block table, one-entry-per-cycle walk logic, totals and the
// result register. Rewriting walks copy into the idle bank, which then swaps.
// ----------------------------------------------------------------------------
module tsbt_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  tsbt_pkg::req_t  req,
	input  tsbt_pkg::cmd_t  cmd,
	output tsbt_pkg::stat_t stat,
	output tsbt_pkg::rsp_t  rsp
);
	import tsbt_pkg::*;

	entry_t             tbl_q [2*MAX_BLOCKS];
	entry_t             rd_s1;
	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic [2:0]         op_q;
	logic [31:0]        l_q, r_q;
	logic [4:0]         keep_q;
	logic [CNT_W-1:0]   cnt_q, iss_q, w_q, a_q;
	logic [31:0]        tot_q;
	logic               ord_q, bank_q;
	logic [IDX_W-1:0]   ri_q;
	logic               stop_q, ins_q, any_rm_q;
	logic [MAX_BLOCKS-1:0] rm_q;
	logic [31:0]        bl_q, br_q, gr_q, skip_q;
	logic               hit_q, gf_q;
	rsp_t               rsp_q;

	logic [31:0]        l_d, r_d, tot_d, bl_d, br_d, gr_d, skip_d;
	logic               stop_d, ins_d, hit_d, gf_d;
	logic [CNT_W-1:0]   a_d;
	logic               rm_set, keep, walk_wr, proc, issue;
	logic [31:0]        wr_left;
	logic [31:0]        s, e, len;
	logic               lt_r_s, gt_l_e, ge_l_s, le_r_e, ge_l_e, gt_l_s, lt_r_e;
	logic               drop, ins_ord, off;
	logic [IDX_W-1:0]   wa_walk;
	logic [IDX_W:0]     wr_addr;
	entry_t             wr_data;
	logic               tbl_we;
	logic [CNT_W-1:0]   cnt_new;
	logic [31:0]        tot_new;
	logic               ord_new, flip, full_st;

	assign s     = rd_s1.left_edge;
	assign e     = rd_s1.right_edge;
	assign len   = e - s;
	assign proc  = cmd.walk_en && v_s1;
	assign issue = cmd.walk_en && (iss_q != '0);

	// modular compares of the current range against the entry
	assign lt_r_s = seq_lt(r_q, s);
	assign gt_l_e = seq_lt(e, l_q);
	assign ge_l_s = !seq_lt(l_q, s);
	assign le_r_e = !seq_lt(e, r_q);
	assign ge_l_e = !seq_lt(l_q, e);
	assign gt_l_s = seq_lt(s, l_q);
	assign lt_r_e = seq_lt(r_q, e);

	// ordered add: dropped when full and nothing merged
	assign drop    = ins_q && !any_rm_q && (cnt_q == CNT_W'(MAX_BLOCKS));
	assign ins_ord = ins_q && !drop;

	// copy address, shifted by one past the insert point
	always_comb begin
		off = 1'b0;
		if (op_q == OP_ADD_ORD)
			off = ins_ord && (CNT_W'(idx_s1) >= a_q);
		else if (op_q == OP_ADD_UNORD)
			off = 1'b1;
	end
	assign wa_walk = IDX_W'(w_q + CNT_W'(off));

	// per-entry decisions
	always_comb begin
		l_d     = l_q;
		r_d     = r_q;
		tot_d   = tot_q;
		stop_d  = stop_q;
		a_d     = a_q;
		ins_d   = ins_q;
		bl_d    = bl_q;
		br_d    = br_q;
		hit_d   = hit_q;
		gr_d    = gr_q;
		gf_d    = gf_q;
		skip_d  = skip_q;
		rm_set  = 1'b0;
		keep    = 1'b1;
		wr_left = s;
		walk_wr = 1'b0;
		if (proc) begin
			if (cmd.scan) begin
				// descending walk for ordered add
				if (!stop_q) begin
					priority if (lt_r_s) begin
					end else if (gt_l_e) begin
						a_d    = CNT_W'(idx_s1) + CNT_W'(1);
						stop_d = 1'b1;
					end else if (ge_l_s && le_r_e) begin
						bl_d   = s;
						br_d   = e;
						hit_d  = 1'b1;
						ins_d  = 1'b0;
						stop_d = 1'b1;
					end else begin
						l_d    = gt_l_s ? s : l_q;
						r_d    = lt_r_e ? e : r_q;
						tot_d  = tot_q - len;
						rm_set = 1'b1;
					end
				end
			end else begin
				walk_wr = 1'b1;
				unique case (op_q)
					OP_ADD_ORD: keep = !rm_q[idx_s1];
					OP_ADD_UNORD: begin
						if (!(gt_l_e || lt_r_s)) begin
							l_d   = gt_l_s ? s : l_q;
							r_d   = lt_r_e ? e : r_q;
							tot_d = tot_q - len;
							keep  = 1'b0;
						end
					end
					OP_FIND: begin
						if (!stop_q && !ge_l_e) begin
							if (ge_l_s) begin
								bl_d   = s;
								br_d   = e;
								hit_d  = 1'b1;
								stop_d = 1'b1;
							end else if (ord_q) begin
								stop_d = 1'b1;
							end
						end
					end
					OP_GAP: begin
						if (!stop_q) begin
							priority if (ge_l_e) begin
								skip_d = skip_q + len;
							end else if (ge_l_s) begin
								skip_d = skip_q + (e - l_q);
								l_d    = e;
							end else begin
								gr_d   = s;
								gf_d   = 1'b1;
								stop_d = 1'b1;
							end
						end
					end
					OP_PRUNE: begin
						if (!stop_q) begin
							if (ge_l_e) begin
								keep  = 1'b0;
								tot_d = tot_q - len;
							end else begin
								if (gt_l_s) begin
									tot_d   = tot_q - (l_q - s);
									wr_left = l_q;
								end
								if (ord_q)
									stop_d = 1'b1;
							end
						end
					end
					OP_LIMIT: begin
						if ((CNT_W + 1)'(idx_s1) >= (CNT_W + 1)'(keep_q)) begin
							keep  = 1'b0;
							tot_d = tot_q - len;
						end
					end
					default: walk_wr = 1'b0;
				endcase
			end
		end
		if (cmd.ins_en) begin
			tot_d = tot_q + (r_q - l_q);
			bl_d  = l_q;
			br_d  = r_q;
			hit_d = 1'b1;
		end
	end

	// table write port, into the idle bank
	always_comb begin
		tbl_we = cmd.ins_en || (walk_wr && keep);
		if (cmd.ins_en) begin
			wr_addr = {~bank_q, a_q[IDX_W-1:0]};
			wr_data = '{left_edge: l_q, right_edge: r_q};
		end else begin
			wr_addr = {~bank_q, wa_walk};
			wr_data = '{left_edge: wr_left, right_edge: e};
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_q[wr_addr] <= wr_data;
		if (issue)
			rd_s1 <= tbl_q[{bank_q, ri_q}];
	end

	// end-of-operation state
	always_comb begin
		cnt_new = cnt_q;
		tot_new = tot_q;
		ord_new = ord_q;
		flip    = 1'b0;
		full_st = 1'b0;
		unique case (op_q)
			OP_ADD_ORD: begin
				cnt_new = w_q + CNT_W'(ins_ord);
				flip    = !drop;
				full_st = drop;
			end
			OP_ADD_UNORD: begin
				if (w_q == CNT_W'(MAX_BLOCKS)) begin
					full_st = 1'b1;
				end else begin
					cnt_new = w_q + CNT_W'(1);
					ord_new = (w_q == '0);
					flip    = 1'b1;
				end
			end
			OP_PRUNE: begin
				cnt_new = w_q;
				flip    = 1'b1;
				if (!stop_q && w_q <= CNT_W'(1))
					ord_new = 1'b1;
			end
			OP_LIMIT: begin
				cnt_new = w_q;
				flip    = 1'b1;
				if (w_q <= CNT_W'(1))
					ord_new = 1'b1;
			end
			OP_CLEAR: begin
				cnt_new = '0;
				tot_new = '0;
				ord_new = 1'b1;
			end
			default: ;
		endcase
	end

	// table state and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			tot_q  <= '0;
			ord_q  <= 1'b1;
			bank_q <= 1'b0;
			v_s1   <= 1'b0;
			iss_q  <= '0;
			ri_q   <= '0;
			w_q    <= '0;
			stop_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				cnt_q  <= cnt_new;
				tot_q  <= tot_new;
				ord_q  <= ord_new;
				bank_q <= bank_q ^ flip;
			end else begin
				tot_q <= tot_d;
			end
			if (cmd.load) begin
				iss_q  <= cnt_q;
				ri_q   <= (req.operation == OP_ADD_ORD) ? IDX_W'(cnt_q - CNT_W'(1)) : '0;
				v_s1   <= 1'b0;
				w_q    <= '0;
				stop_q <= 1'b0;
			end else if (cmd.walk_start) begin
				iss_q  <= cnt_q;
				ri_q   <= '0;
				v_s1   <= 1'b0;
				w_q    <= '0;
				stop_q <= 1'b0;
			end else if (cmd.walk_en) begin
				v_s1   <= issue;
				stop_q <= stop_d;
				if (issue) begin
					ri_q  <= cmd.scan ? ri_q - IDX_W'(1) : ri_q + IDX_W'(1);
					iss_q <= iss_q - CNT_W'(1);
				end
				if (walk_wr && keep)
					w_q <= w_q + CNT_W'(1);
			end
		end
	end

	// working registers of the current operation
	always_ff @(posedge clk) begin
		if (issue)
			idx_s1 <= ri_q;
		if (cmd.load) begin
			op_q     <= req.operation;
			l_q      <= req.seq_left;
			r_q      <= req.seq_right;
			keep_q   <= req.keep_count;
			a_q      <= '0;
			ins_q    <= 1'b1;
			any_rm_q <= 1'b0;
			rm_q     <= '0;
			bl_q     <= '0;
			br_q     <= '0;
			hit_q    <= 1'b0;
			gr_q     <= req.seq_right;
			gf_q     <= 1'b0;
			skip_q   <= '0;
		end else begin
			l_q    <= l_d;
			r_q    <= r_d;
			a_q    <= a_d;
			ins_q  <= ins_d;
			bl_q   <= bl_d;
			br_q   <= br_d;
			hit_q  <= hit_d;
			gr_q   <= gr_d;
			gf_q   <= gf_d;
			skip_q <= skip_d;
			if (rm_set) begin
				rm_q[idx_s1] <= 1'b1;
				any_rm_q     <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.block_left    <= bl_q;
			rsp_q.block_right   <= br_q;
			rsp_q.block_hit     <= hit_q;
			rsp_q.gap_left      <= (op_q == OP_GAP) ? l_q : '0;
			rsp_q.gap_right     <= (op_q == OP_GAP) ? gr_q : '0;
			rsp_q.gap_found     <= gf_q;
			rsp_q.skipped_bytes <= gf_q ? skip_q : '0;
			rsp_q.block_count   <= 5'(cnt_new);
			rsp_q.total_bytes   <= tot_new;
			rsp_q.is_ordered    <= ord_new;
			rsp_q.status        <= full_st;
		end
	end

	assign rsp             = rsp_q;
	assign stat.walk_end   = (iss_q == '0) && !v_s1;
	assign stat.ins_needed = (op_q == OP_ADD_ORD && ins_ord)
		|| (op_q == OP_ADD_UNORD && w_q != CNT_W'(MAX_BLOCKS));

endmodule

[hw/rtl/tcp_sequence_block_tracker.sv]
// ----------------------------------------------------------------------------
// tcp_sequence_block_tracker
// Table of up to 16 disjoint received sequence blocks with add, find, gap,
// prune, limit and clear operations.
// ----------------------------------------------------------------------------
// channel  direction  signals
// req      in         req_valid, req_ready, req (operation, edges, keep count)
// rsp      out        rsp_valid, rsp_ready, rsp (block, gap, totals, status)
//
// one table entry is read per cycle during a walk.
// ordered add runs a scan, a copy and an insert; unordered add a copy and an
// insert; find, gap, prune and limit one walk; clear and unused codes no walk.
// a new request is taken while the previous result waits in the output register.
// reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module tcp_sequence_block_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tsbt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tsbt_pkg::rsp_t rsp
);
	import tsbt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	tsbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.operation),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table and arithmetic
	tsbt_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

[hw/rtl/tsbt_checker.sv]
// ----------------------------------------------------------------------------
// tsbt_checker
// Port-level checks for the block tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "tcp_sequence_block_tracker_assert.svh"

module tsbt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input tsbt_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input tsbt_pkg::rsp_t rsp
);
	import tsbt_pkg::*;

	// a stalled result holds
	`TSBT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

	// count never exceeds the table
	`TSBT_ASSERT_IMP(a_count_max, rsp_valid, rsp.block_count <= 5'(MAX_BLOCKS), "block count above table size")

	// a dropped add never reports a block
	`TSBT_ASSERT_IMP(a_full_nohit, rsp_valid && rsp.status, !rsp.block_hit, "dropped add reported a block")

	// skipped bytes only come with a gap
	`TSBT_ASSERT_IMP(a_skip_gap, rsp_valid && !rsp.gap_found, rsp.skipped_bytes == 32'd0, "skipped bytes without gap")

endmodule

bind tcp_sequence_block_tracker tsbt_checker u_tsbt_checker (.*);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed range operations into the sequence block tracker
// and checks every result against a behavioral table model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tsbt_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// table model state
	logic [31:0] blk_lo [MAX_BLOCKS];
	logic [31:0] blk_hi [MAX_BLOCKS];
	int unsigned blk_cnt;
	logic [31:0] blk_bytes;
	logic blk_sorted;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors = 0;
	int cycle = 0;
	bit stim_done = 0;
	bit quiet = 0;

	tcp_sequence_block_tracker uut (.*);

	always #1 clk = ~clk;

	function automatic bit slt(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic void drop_block(int unsigned i);
		blk_bytes -= blk_hi[i] - blk_lo[i];
		for (int unsigned k = i; k + 1 < blk_cnt; k++) begin
			blk_lo[k] = blk_lo[k+1];
			blk_hi[k] = blk_hi[k+1];
		end
		blk_cnt--;
	endfunction

	function automatic bit put_block(int unsigned p, logic [31:0] l, logic [31:0] r);
		if (blk_cnt >= MAX_BLOCKS || p > blk_cnt) return 0;
		for (int unsigned k = blk_cnt; k > p; k--) begin
			blk_lo[k] = blk_lo[k-1];
			blk_hi[k] = blk_hi[k-1];
		end
		blk_lo[p] = l;
		blk_hi[p] = r;
		blk_cnt++;
		blk_bytes += r - l;
		return 1;
	endfunction

	// compute the response of one request and update the table
	function automatic rsp_t track_op(req_t q);
		rsp_t o;
		logic [31:0] l, r, el, er;
		int unsigned i, pos;
		bit done, stopped;
		o = '0;
		l = q.seq_left;
		r = q.seq_right;
		case (q.operation)
			OP_ADD_ORD: begin
				done = 0;
				pos = 0;
				i = blk_cnt;
				while (i > 0) begin
					i--;
					if (slt(r, blk_lo[i])) continue;
					if (slt(blk_hi[i], l)) begin
						pos = i + 1;
						break;
					end
					if (!slt(l, blk_lo[i]) && !slt(blk_hi[i], r)) begin
						o.block_left = blk_lo[i];
						o.block_right = blk_hi[i];
						o.block_hit = 1;
						done = 1;
						break;
					end
					if (slt(blk_lo[i], l)) l = blk_lo[i];
					if (slt(r, blk_hi[i])) r = blk_hi[i];
					drop_block(i);
				end
				if (!done) begin
					if (put_block(pos, l, r)) begin
						o.block_left = l;
						o.block_right = r;
						o.block_hit = 1;
					end else o.status = 1;
				end
			end
			OP_ADD_UNORD: begin
				i = 0;
				while (i < blk_cnt) begin
					if (slt(blk_hi[i], l) || slt(r, blk_lo[i])) begin
						i++;
						continue;
					end
					if (slt(blk_lo[i], l)) l = blk_lo[i];
					if (slt(r, blk_hi[i])) r = blk_hi[i];
					drop_block(i);
				end
				if (blk_cnt < MAX_BLOCKS) begin
					blk_sorted = (blk_cnt == 0);
					void'(put_block(0, l, r));
					o.block_left = l;
					o.block_right = r;
					o.block_hit = 1;
				end else o.status = 1;
			end
			OP_FIND: begin
				for (i = 0; i < blk_cnt; i++) begin
					if (!slt(l, blk_hi[i])) continue;
					if (!slt(l, blk_lo[i])) begin
						o.block_left = blk_lo[i];
						o.block_right = blk_hi[i];
						o.block_hit = 1;
						break;
					end
					if (blk_sorted) break;
				end
			end
			OP_GAP: begin
				o.gap_right = r;
				for (i = 0; i < blk_cnt; i++) begin
					el = blk_lo[i];
					er = blk_hi[i];
					if (!slt(l, er)) begin
						o.skipped_bytes += er - el;
						continue;
					end
					if (!slt(l, el)) begin
						o.skipped_bytes += er - l;
						l = er;
						continue;
					end
					o.gap_right = el;
					o.gap_found = 1;
					break;
				end
				o.gap_left = l;
				if (!o.gap_found) o.skipped_bytes = 0;
			end
			OP_PRUNE: begin
				stopped = 0;
				i = 0;
				while (i < blk_cnt) begin
					if (!slt(l, blk_hi[i])) begin
						drop_block(i);
						continue;
					end
					if (slt(blk_lo[i], l)) begin
						blk_bytes -= l - blk_lo[i];
						blk_lo[i] = l;
					end
					if (blk_sorted) begin
						stopped = 1;
						break;
					end
					i++;
				end
				if (!stopped && blk_cnt <= 1) blk_sorted = 1;
			end
			OP_LIMIT: begin
				while (blk_cnt > q.keep_count) drop_block(blk_cnt - 1);
				if (blk_cnt <= 1) blk_sorted = 1;
			end
			OP_CLEAR: begin
				blk_cnt = 0;
				blk_bytes = 0;
				blk_sorted = 1;
			end
			default: ;
		endcase
		o.block_count = blk_cnt[4:0];
		o.total_bytes = blk_bytes;
		o.is_ordered = blk_sorted;
		return o;
	endfunction

	function automatic void queue_op(logic [2:0] op, logic [31:0] l, logic [31:0] r,
			logic [4:0] k);
		req_t q;
		q.operation = op;
		q.seq_left = l;
		q.seq_right = r;
		q.keep_count = k;
		pending_reqs.push_back(q);
	endfunction

	// ranges near a moving base so merges and gaps actually happen
	logic [31:0] base;
	function automatic void queue_random();
		int unsigned sel;
		logic [31:0] l;
		sel = $urandom_range(0, 99);
		l = base + $urandom_range(0, 400);
		if (sel < 2) queue_op(3'($urandom_range(0, 7)), $urandom, $urandom,
			5'($urandom_range(0, 31)));
		else if (sel < 40) queue_op(OP_ADD_ORD, l, l + $urandom_range(1, 40), 0);
		else if (sel < 52) queue_op(OP_ADD_UNORD, l, l + $urandom_range(1, 40), 0);
		else if (sel < 55) queue_op(OP_ADD_ORD, l, l - $urandom_range(1, 8), 5'($urandom));
		else if (sel < 68) queue_op(OP_FIND, l, $urandom, 5'($urandom));
		else if (sel < 80) queue_op(OP_GAP, base + $urandom_range(0, 200),
			base + $urandom_range(0, 600), 0);
		else if (sel < 88) begin
			queue_op(OP_PRUNE, base + $urandom_range(0, 150), $urandom, 0);
			base += $urandom_range(0, 120);
		end else if (sel < 95) queue_op(OP_LIMIT, $urandom, $urandom,
			5'($urandom_range(0, 18)));
		else if (sel < 97) queue_op(OP_CLEAR, $urandom, $urandom, 0);
		else queue_op(OP_ADD_ORD, base + 32'h8000_0000, base + 32'h8000_0010, 0);
	endfunction

	// stimulus
	initial begin
		blk_cnt = 0;
		blk_bytes = 0;
		blk_sorted = 1;
		base = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, wrap, reversed range, fill beyond capacity
		queue_op(OP_FIND, 32'h0, 32'h0, 0);
		queue_op(OP_GAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		queue_op(OP_ADD_ORD, 32'hFFFF_FFF0, 32'h0000_0010, 5'h1F);
		queue_op(OP_ADD_ORD, 32'h0000_0100, 32'h0000_0050, 0);
		queue_op(OP_GAP, 32'hFFFF_FFE0, 32'h0000_2000, 0);
		queue_op(OP_FIND, 32'h0000_0005, 0, 0);
		for (int k = 0; k < 17; k++)
			queue_op(OP_ADD_ORD, 32'h1000 + k * 32, 32'h1008 + k * 32, 0);
		queue_op(OP_ADD_UNORD, 32'h9000, 32'h9010, 0);
		queue_op(OP_LIMIT, 0, 0, 5'd16);
		queue_op(OP_ADD_UNORD, 32'h1004, 32'h1030, 0);
		queue_op(OP_PRUNE, 32'h1100, 0, 0);
		queue_op(OP_LIMIT, 0, 0, 5'd0);
		queue_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h1F);
		queue_op(OP_CLEAR, 0, 0, 0);
		for (int n = 0; n < 1550; n++) queue_random();
		stim_done = 1;
	end

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(track_op(req));
				void'(pending_reqs.pop_front());
			end
			if (pending_reqs.size() > (req_valid && req_ready ? 0 : 0) &&
					(!req_valid || req_ready)) begin
				if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 20)) begin
					req_valid <= 1'b1;
					req <= pending_reqs[0];
				end else req_valid <= 1'b0;
			end else if (req_valid && req_ready) req_valid <= 1'b0;
			rsp_ready <= quiet || $urandom_range(0, 99) >= 20;
		end
	end

	// response monitor and checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected response transfer");
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.block_left !== e.block_left) begin
					$error("block_left exp %h got %h", e.block_left, rsp.block_left); errors++; end
				if (rsp.block_right !== e.block_right) begin
					$error("block_right exp %h got %h", e.block_right, rsp.block_right); errors++; end
				if (rsp.block_hit !== e.block_hit) begin
					$error("block_hit exp %b got %b", e.block_hit, rsp.block_hit); errors++; end
				if (rsp.gap_left !== e.gap_left) begin
					$error("gap_left exp %h got %h", e.gap_left, rsp.gap_left); errors++; end
				if (rsp.gap_right !== e.gap_right) begin
					$error("gap_right exp %h got %h", e.gap_right, rsp.gap_right); errors++; end
				if (rsp.gap_found !== e.gap_found) begin
					$error("gap_found exp %b got %b", e.gap_found, rsp.gap_found); errors++; end
				if (rsp.skipped_bytes !== e.skipped_bytes) begin
					$error("skipped_bytes exp %h got %h", e.skipped_bytes, rsp.skipped_bytes);
					errors++;
				end
				if (rsp.block_count !== e.block_count) begin
					$error("block_count exp %0d got %0d", e.block_count, rsp.block_count); errors++; end
				if (rsp.total_bytes !== e.total_bytes) begin
					$error("total_bytes exp %h got %h", e.total_bytes, rsp.total_bytes); errors++; end
				if (rsp.is_ordered !== e.is_ordered) begin
					$error("is_ordered exp %b got %b", e.is_ordered, rsp.is_ordered); errors++; end
				if (rsp.status !== e.status) begin
					$error("status exp %b got %b", e.status, rsp.status); errors++; end
			end
		end
	end

	// stretch with no idling on either side
	always @(posedge clk) begin
		cycle <= cycle + 1;
		quiet <= (cycle >= 20000 && cycle < 24000);
	end

	// end of run
	initial begin
		wait (arst_n);
		while (!(stim_done && pending_reqs.size() == 0 && !req_valid &&
				expected_rsps.size() == 0) && cycle < LIMIT_CYCLES)
			@(posedge clk);
		if (cycle >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
		end else begin
			repeat (60) @(posedge clk);
			if (errors == 0 && expected_rsps.size() == 0) $display("*** PASSED ***");
			else $display("*** FAILED ***");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tsbt_pkg.sv
hw/rtl/tsbt_ctrl.sv
hw/rtl/tsbt_datapath.sv
hw/rtl/tcp_sequence_block_tracker.sv
hw/rtl/tsbt_checker.sv
tb/testbench.sv
